@@ rtl/bfd_pkg.sv @@
// Shared types, constants and the reciprocal table of the box filter downsampler.
// Depends on nothing; the other files but bfd_acc_mem use it, the testbench by import.
`default_nettype none

package bfd_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_FACTOR_DEF = 16;
  localparam int MAX_HEIGHT     = 4096;

  localparam int COL_W  = 8;
  localparam int HITS_W = 32;
  localparam int SUM_W  = 16;
  localparam int POS_W  = 12;
  localparam int SUB_W  = 4;
  localparam int FAC_W  = 5;
  localparam int DIM_W  = 13;
  localparam int HGT_W  = 13;
  localparam int IDX_W  = 2;

  localparam int RECIP_W  = 25;
  localparam int RECIP_SH = 24;
  localparam int PROD_W   = SUM_W + RECIP_W;

  localparam logic [IDX_W-1:0] CFG_FACTOR = 2'd0;
  localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [FAC_W-1:0] FACTOR_RST = 5'd1;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd1024;

  typedef struct packed {
    logic [HITS_W-1:0] hits;
    logic [SUM_W-1:0]  blue;
    logic [SUM_W-1:0]  green;
    logic [SUM_W-1:0]  red;
  } acc_t;

  typedef struct packed {
    logic             acc;
    logic             first;
    logic             last;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } item_ctl_t;

  typedef struct packed {
    acc_t             sums;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } res_t;

  // Rounded-up 2^24 / (f*f); the product with any 16-bit sum, shifted by 24,
  // gives the exact truncated quotient.
  function automatic logic [RECIP_W-1:0] recip(input logic [FAC_W-1:0] f);
    logic [RECIP_W-1:0] r;
    case (f)
      5'd2:    r = 25'd4194304;
      5'd3:    r = 25'd1864136;
      5'd4:    r = 25'd1048576;
      5'd5:    r = 25'd671089;
      5'd6:    r = 25'd466034;
      5'd7:    r = 25'd342393;
      5'd8:    r = 25'd262144;
      5'd9:    r = 25'd207127;
      5'd10:   r = 25'd167773;
      5'd11:   r = 25'd138655;
      5'd12:   r = 25'd116509;
      5'd13:   r = 25'd99274;
      5'd14:   r = 25'd85599;
      5'd15:   r = 25'd74566;
      5'd16:   r = 25'd65536;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bfd_if.sv @@
// Handshake interfaces of the box filter downsampler: pixel input, block result
// and configuration write. Depends on bfd_pkg for field widths.
`default_nettype none

interface bfd_pix_if;
  logic                           valid;
  logic                           ready;
  logic [bfd_pkg::COL_W-1:0]      red_in;
  logic [bfd_pkg::COL_W-1:0]      green_in;
  logic [bfd_pkg::COL_W-1:0]      blue_in;
  logic [bfd_pkg::HITS_W-1:0]     hits_in;
  modport source (output valid, red_in, green_in, blue_in, hits_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, hits_in, output ready);
endinterface

interface bfd_res_if;
  logic                           valid;
  logic                           ready;
  logic [bfd_pkg::COL_W-1:0]      red_avg;
  logic [bfd_pkg::COL_W-1:0]      green_avg;
  logic [bfd_pkg::COL_W-1:0]      blue_avg;
  logic [bfd_pkg::HITS_W-1:0]     hits_sum;
  logic [bfd_pkg::POS_W-1:0]      out_x;
  logic [bfd_pkg::POS_W-1:0]      out_y;
  modport source (output valid, red_avg, green_avg, blue_avg, hits_sum, out_x, out_y,
                  input ready);
  modport sink (input valid, red_avg, green_avg, blue_avg, hits_sum, out_x, out_y,
                output ready);
endinterface

interface bfd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bfd_pkg::IDX_W-1:0]      index;
  logic [bfd_pkg::DIM_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/box_filter_downsampler.sv @@
// Top level of the box filter downsampler: position sequencer, accumulator
// memory with read-modify-write stage, averaging stage.
// Depends on bfd_pkg, the bfd interfaces, bfd_ctrl, bfd_acc_mem and bfd_avg.
`default_nettype none

// Pixels arrive in raster order and are summed per block column in a memory of
// MAX_WIDTH entries, each read when the pixel is taken and written back from the
// registered stage after it, with the previous write forwarded when it hits the
// same column. An ordinary pixel is taken every cycle while the averaging stage
// is not busy. The pixel that closes a block holds the input off while its sums
// move into the averaging stage, longer if the result port stalls. Its result
// passes through the holding register to the output register. Accumulators
// need no clearing after reset: the first pixel of every block loads them.
// A configuration write restarts the frame at the origin.
module box_filter_downsampler #(
  parameter int MAX_WIDTH  = bfd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = bfd_pkg::MAX_FACTOR_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bfd_pix_if.sink   in_ch,
  bfd_res_if.source out_ch,
  bfd_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DW = $bits(bfd_pkg::acc_t);

  bfd_pkg::item_ctl_t         ctl;
  logic [bfd_pkg::FAC_W-1:0]  fac;
  logic                       in_acc;
  logic                       avg_busy;

  logic               s1_v_r;
  bfd_pkg::item_ctl_t s1_ctl_r;
  bfd_pkg::acc_t      s1_pix_r, pix;

  logic [AW-1:0]      rd_addr, s1_idx;
  bfd_pkg::acc_t      rd_data, base, acc_nxt;

  logic               fwd_v_r;
  logic [AW-1:0]      fwd_idx_r;
  bfd_pkg::acc_t      fwd_data_r;

  bfd_pkg::res_t      res;
  logic               res_ld;

  assign in_ch.ready = !avg_busy && !(s1_v_r && s1_ctl_r.last);
  assign in_acc      = in_ch.valid && in_ch.ready;

  bfd_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_acc (in_acc),
    .ctl    (ctl),
    .fac    (fac)
  );

  always_comb begin
    pix.red   = bfd_pkg::SUM_W'(in_ch.red_in);
    pix.green = bfd_pkg::SUM_W'(in_ch.green_in);
    pix.blue  = bfd_pkg::SUM_W'(in_ch.blue_in);
    pix.hits  = in_ch.hits_in;
    rd_addr   = AW'({{AW{1'b0}}, ctl.col});
    s1_idx    = AW'({{AW{1'b0}}, s1_ctl_r.col});
  end

  bfd_acc_mem #(
    .AW (AW),
    .DW (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (s1_v_r),
    .wr_addr (s1_idx),
    .wr_data (acc_nxt),
    .rd_en   (in_acc && ctl.acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    base = (fwd_v_r && (fwd_idx_r == s1_idx)) ? fwd_data_r : rd_data;
    if (s1_ctl_r.first) begin
      acc_nxt = s1_pix_r;
    end else begin
      acc_nxt.red   = base.red + s1_pix_r.red;
      acc_nxt.green = base.green + s1_pix_r.green;
      acc_nxt.blue  = base.blue + s1_pix_r.blue;
      acc_nxt.hits  = base.hits + s1_pix_r.hits;
    end
    res.sums = acc_nxt;
    res.x    = s1_ctl_r.col;
    res.y    = s1_ctl_r.row;
    res_ld   = s1_v_r && s1_ctl_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r  <= in_acc && ctl.acc;
      fwd_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r <= ctl;
      s1_pix_r <= pix;
    end
    fwd_idx_r  <= s1_idx;
    fwd_data_r <= acc_nxt;
  end

  bfd_avg u_avg (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld     (res_ld),
    .res    (res),
    .fac    (fac),
    .busy   (avg_busy),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

@@ rtl/bfd_acc_mem.sv @@
// Accumulator memory: one write port and one registered read port.
// Depends on nothing beyond its parameters.
`default_nettype none

module bfd_acc_mem #(
  parameter int AW = 12,
  parameter int DW = 80
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bfd_ctrl.sv @@
// Configuration registers and raster position sequencer of the downsampler.
// Depends on bfd_pkg and the bfd_cfg_if interface.
`default_nettype none

module bfd_ctrl #(
  parameter int MAX_WIDTH  = bfd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = bfd_pkg::MAX_FACTOR_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  bfd_cfg_if.sink                       cfg_ch,
  input  wire logic                     in_acc,
  output bfd_pkg::item_ctl_t            ctl,
  output logic [bfd_pkg::FAC_W-1:0]     fac
);

  localparam int XW = $clog2(MAX_WIDTH) + 1;
  localparam int FW = bfd_pkg::FAC_W;
  localparam int HW = bfd_pkg::HGT_W;
  localparam int PW = bfd_pkg::POS_W;
  localparam int SW = bfd_pkg::SUB_W;

  logic [FW-1:0]            factor_r;
  logic [bfd_pkg::DIM_W-1:0] width_r;
  logic [HW-1:0]            height_r;

  logic [XW-1:0] x_r, x_nxt, col_base_r, col_base_nxt;
  logic [HW-1:0] y_r, y_nxt, row_base_r, row_base_nxt;
  logic [PW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [SW-1:0] sub_col_r, sub_col_nxt, sub_row_r, sub_row_nxt;

  logic [XW-1:0] w_c;
  logic [HW-1:0] h_c;
  logic [FW-1:0] sc_inc, sr_inc;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= bfd_pkg::FACTOR_RST;
      width_r  <= bfd_pkg::WIDTH_RST;
      height_r <= bfd_pkg::HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bfd_pkg::CFG_FACTOR: factor_r <= cfg_ch.data[FW-1:0];
        bfd_pkg::CFG_WIDTH:  width_r  <= cfg_ch.data;
        bfd_pkg::CFG_HEIGHT: height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (factor_r == '0) begin
      fac = FW'(1);
    end else if (32'(factor_r) > MAX_FACTOR) begin
      fac = FW'(MAX_FACTOR);
    end else begin
      fac = factor_r;
    end
    if (width_r == '0) begin
      w_c = XW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_c = XW'(MAX_WIDTH);
    end else begin
      w_c = XW'(width_r);
    end
    if (height_r == '0) begin
      h_c = HW'(1);
    end else if (32'(height_r) > bfd_pkg::MAX_HEIGHT) begin
      h_c = HW'(bfd_pkg::MAX_HEIGHT);
    end else begin
      h_c = height_r;
    end
  end

  always_comb begin
    ctl.acc   = (({1'b0, col_base_r} + (XW+1)'(fac)) <= {1'b0, w_c}) &&
                (({1'b0, row_base_r} + (HW+1)'(fac)) <= {1'b0, h_c});
    ctl.first = (sub_col_r == '0) && (sub_row_r == '0);
    ctl.last  = ({1'b0, sub_col_r} == fac - FW'(1)) && ({1'b0, sub_row_r} == fac - FW'(1));
    ctl.col   = col_r;
    ctl.row   = row_r;
  end

  always_comb begin
    sc_inc       = {1'b0, sub_col_r} + FW'(1);
    sr_inc       = {1'b0, sub_row_r} + FW'(1);
    x_nxt        = x_r;
    col_base_nxt = col_base_r;
    col_nxt      = col_r;
    sub_col_nxt  = sub_col_r;
    y_nxt        = y_r;
    row_base_nxt = row_base_r;
    row_nxt      = row_r;
    sub_row_nxt  = sub_row_r;
    if (x_r >= w_c - XW'(1)) begin
      x_nxt        = '0;
      col_base_nxt = '0;
      col_nxt      = '0;
      sub_col_nxt  = '0;
      if (y_r >= h_c - HW'(1)) begin
        y_nxt        = '0;
        row_base_nxt = '0;
        row_nxt      = '0;
        sub_row_nxt  = '0;
      end else begin
        y_nxt = y_r + HW'(1);
        if (sr_inc >= fac) begin
          sub_row_nxt  = '0;
          row_nxt      = row_r + PW'(1);
          row_base_nxt = row_base_r + HW'(fac);
        end else begin
          sub_row_nxt = SW'(sr_inc);
        end
      end
    end else begin
      x_nxt = x_r + XW'(1);
      if (sc_inc >= fac) begin
        sub_col_nxt  = '0;
        col_nxt      = col_r + PW'(1);
        col_base_nxt = col_base_r + XW'(fac);
      end else begin
        sub_col_nxt = SW'(sc_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_ch.valid) begin
      x_r        <= '0;
      col_base_r <= '0;
      col_r      <= '0;
      sub_col_r  <= '0;
      y_r        <= '0;
      row_base_r <= '0;
      row_r      <= '0;
      sub_row_r  <= '0;
    end else if (in_acc) begin
      x_r        <= x_nxt;
      col_base_r <= col_base_nxt;
      col_r      <= col_nxt;
      sub_col_r  <= sub_col_nxt;
      y_r        <= y_nxt;
      row_base_r <= row_base_nxt;
      row_r      <= row_nxt;
      sub_row_r  <= sub_row_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bfd_avg.sv @@
// Result holding register and averaging stage: reciprocal multiply of the block
// sums, output register. Depends on bfd_pkg and the bfd_res_if interface.
`default_nettype none

module bfd_avg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 ld,
  input  wire bfd_pkg::res_t        res,
  input  wire logic [bfd_pkg::FAC_W-1:0] fac,
  output logic                      busy,
  bfd_res_if.source                 out_ch
);

  localparam int PW = bfd_pkg::PROD_W;
  localparam int SH = bfd_pkg::RECIP_SH;
  localparam int CW = bfd_pkg::COL_W;

  logic          hold_v_r, hold_v_nxt;
  bfd_pkg::res_t hold_r;
  logic          out_v_r, out_v_nxt;
  logic          moving;

  logic [bfd_pkg::RECIP_W-1:0] rcp;
  logic [PW-1:0]               prod_red, prod_green, prod_blue;

  logic [CW-1:0]                red_r, green_r, blue_r;
  logic [bfd_pkg::HITS_W-1:0]   hits_r;
  logic [bfd_pkg::POS_W-1:0]    x_r, y_r;

  assign moving = hold_v_r && (!out_v_r || out_ch.ready);
  assign busy   = hold_v_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (ld) begin
      hold_v_nxt = 1'b1;
    end else if (moving) begin
      hold_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (moving) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_comb begin
    rcp        = bfd_pkg::recip(fac);
    prod_red   = PW'(hold_r.sums.red) * PW'(rcp);
    prod_green = PW'(hold_r.sums.green) * PW'(rcp);
    prod_blue  = PW'(hold_r.sums.blue) * PW'(rcp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      hold_r <= res;
    end
    if (moving) begin
      red_r   <= prod_red[SH +: CW];
      green_r <= prod_green[SH +: CW];
      blue_r  <= prod_blue[SH +: CW];
      hits_r  <= hold_r.sums.hits;
      x_r     <= hold_r.x;
      y_r     <= hold_r.y;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.red_avg   = red_r;
  assign out_ch.green_avg = green_r;
  assign out_ch.blue_avg  = blue_r;
  assign out_ch.hits_sum  = hits_r;
  assign out_ch.out_x     = x_r;
  assign out_ch.out_y     = y_r;

endmodule

`default_nettype wire

@@ dv/box_filter_downsampler_tb.sv @@
// Self-checking testbench for the box filter downsampler: drives pixels and register
// writes, predicts every block average and compares it with the result channel.
// Depends on bfd_pkg, the bfd interfaces and the box_filter_downsampler RTL.
`default_nettype none

module box_filter_downsampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfd_pkg::*;

  localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned ACC_DEPTH = MAX_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct packed {
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    logic [HITS_W-1:0] hits;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    logic [HITS_W-1:0] hits;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } block_avg_t;

  logic clk = 1'b0;
  logic rst_n;

  bfd_pix_if pix_ch ();
  bfd_res_if res_ch ();
  bfd_cfg_if cfg_ch ();

  box_filter_downsampler i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  logic [FAC_W-1:0]  factor_reg;
  logic [DIM_W-1:0]  width_reg;
  logic [HGT_W-1:0]  height_reg;
  logic [SUM_W-1:0]  red_acc   [ACC_DEPTH];
  logic [SUM_W-1:0]  green_acc [ACC_DEPTH];
  logic [SUM_W-1:0]  blue_acc  [ACC_DEPTH];
  logic [HITS_W-1:0] hits_acc  [ACC_DEPTH];
  int unsigned col_pos, row_pos, sub_col, sub_row;

  pixel_t     pix_pending[$];
  block_avg_t avg_expected[$];
  pixel_t     pix_next;
  block_avg_t avg_want;
  bit          pix_busy = 1'b0;
  int          pix_gap = 0, pix_calm = 0, res_stall = 0, res_calm = 0;
  int          mismatches = 0;
  int unsigned cycles = 0;

  always #5ns clk = ~clk;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Mostly back-to-back or short gaps, a few long ones, and now and then a calm
  // stretch with no gaps at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return '1;
    return COL_W'($urandom);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int r;
    p.red = pick_level();
    p.green = pick_level();
    p.blue = pick_level();
    r = $urandom_range(0, 9);
    p.hits = (r < 2) ? '0 : (r < 4) ? '1 : HITS_W'($urandom);
    return p;
  endfunction

  task automatic box_filter_step(input pixel_t p);
    int unsigned f, w, h, x, y, area, c;
    block_avg_t b;
    f = clamp_dim(factor_reg, MAX_FACTOR_DEF);
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    x = col_pos * f + sub_col;
    y = row_pos * f + sub_row;
    if (col_pos < w / f && row_pos < h / f) begin
      c = col_pos % ACC_DEPTH;
      if (sub_col == 0 && sub_row == 0) begin
        red_acc[c] = p.red;
        green_acc[c] = p.green;
        blue_acc[c] = p.blue;
        hits_acc[c] = p.hits;
      end else begin
        red_acc[c] = red_acc[c] + p.red;
        green_acc[c] = green_acc[c] + p.green;
        blue_acc[c] = blue_acc[c] + p.blue;
        hits_acc[c] = hits_acc[c] + p.hits;
      end
      if (sub_col == f - 1 && sub_row == f - 1) begin
        area = f * f;
        b.red = COL_W'(red_acc[c] / area);
        b.green = COL_W'(green_acc[c] / area);
        b.blue = COL_W'(blue_acc[c] / area);
        b.hits = hits_acc[c];
        b.x = POS_W'(col_pos);
        b.y = POS_W'(row_pos);
        avg_expected.push_back(b);
      end
    end
    if (x >= w - 1) begin
      col_pos = 0;
      sub_col = 0;
      if (y >= h - 1) begin
        row_pos = 0;
        sub_row = 0;
      end else begin
        sub_row++;
        if (sub_row >= f) begin
          sub_row = 0;
          row_pos = (row_pos + 1) % (1 << POS_W);
        end
      end
    end else begin
      sub_col++;
      if (sub_col >= f) begin
        sub_col = 0;
        col_pos = (col_pos + 1) % (1 << POS_W);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [HITS_W-1:0] want,
                             input logic [HITS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic wait_drained();
    while (pix_pending.size() != 0 || pix_busy || avg_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_FACTOR: factor_reg = val[FAC_W-1:0];
      CFG_WIDTH:  width_reg = val;
      CFG_HEIGHT: height_reg = val;
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
    sub_col = 0;
    sub_row = 0;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && pix_ch.valid && pix_ch.ready) begin
      box_filter_step(pixel_t'{pix_ch.red_in, pix_ch.green_in, pix_ch.blue_in,
                               pix_ch.hits_in});
      pix_busy = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!pix_busy) begin
      if (pix_gap > 0) begin
        pix_gap--;
        pix_ch.valid <= 1'b0;
      end else if (pix_pending.size() > 0) begin
        pix_next = pix_pending.pop_front();
        pix_ch.red_in <= pix_next.red;
        pix_ch.green_in <= pix_next.green;
        pix_ch.blue_in <= pix_next.blue;
        pix_ch.hits_in <= pix_next.hits;
        pix_ch.valid <= 1'b1;
        pix_busy = 1'b1;
        pix_gap = pick_gap(pix_calm);
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (res_stall > 0) begin
      res_stall--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      res_stall = pick_gap(res_calm);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (avg_expected.size() == 0) begin
        $display("%0t: expected no block, got x=%0d y=%0d", $time, res_ch.out_x,
                 res_ch.out_y);
        mismatches++;
      end else begin
        avg_want = avg_expected.pop_front();
        check_field("red_avg", avg_want.red, res_ch.red_avg);
        check_field("green_avg", avg_want.green, res_ch.green_avg);
        check_field("blue_avg", avg_want.blue, res_ch.blue_avg);
        check_field("hits_sum", avg_want.hits, res_ch.hits_sum);
        check_field("out_x", avg_want.x, res_ch.out_x);
        check_field("out_y", avg_want.y, res_ch.out_y);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("box_filter_downsampler_tb: errors");
      $finish;
    end
  end

  initial begin
    int f_eff, wb, hb, crop_max, w, h, frame, n, split, sel, phase, items_sent;
    logic [DIM_W-1:0] fac_data, val;
    logic [IDX_W-1:0] reg_order[$];
    rst_n = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.red_in = '0;
    pix_ch.green_in = '0;
    pix_ch.blue_in = '0;
    pix_ch.hits_in = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_FACTOR;
    cfg_ch.data = '0;
    factor_reg = FACTOR_RST;
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    col_pos = 0;
    row_pos = 0;
    sub_col = 0;
    sub_row = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // At the reset factor of one every pixel is its own block.
    pix_pending.push_back(pixel_t'{8'h00, 8'h00, 8'h00, 32'h0000_0000});
    pix_pending.push_back(pixel_t'{8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
    pix_pending.push_back(pixel_t'{8'hAA, 8'h55, 8'hAA, 32'hAAAA_AAAA});
    pix_pending.push_back(pixel_t'{8'h55, 8'hAA, 8'h55, 32'h5555_5555});
    pix_pending.push_back(pixel_t'{8'h01, 8'h80, 8'hFE, 32'h8000_0001});
    wait_drained();

    // A factor of zero acts as one; a small frame wraps, and a write to the
    // unused index restarts it.
    write_reg(CFG_FACTOR, 13'h1FE0);
    write_reg(CFG_WIDTH, 13'd3);
    write_reg(CFG_HEIGHT, 13'd2);
    repeat (4) pix_pending.push_back(rand_pixel());
    wait_drained();
    write_reg(CFG_SPARE, 13'h0AAA);
    repeat (7) pix_pending.push_back(rand_pixel());
    wait_drained();

    // Largest block with every field at its maximum.
    write_reg(CFG_FACTOR, 13'h1FFF);
    write_reg(CFG_WIDTH, 13'd16);
    write_reg(CFG_HEIGHT, 13'd16);
    repeat (256) pix_pending.push_back(pixel_t'{8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
    wait_drained();

    items_sent = 0;
    for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
      sel = $urandom_range(0, 9);
      wb = $urandom_range(1, 5);
      hb = $urandom_range(1, 4);
      if (sel == 0) begin
        f_eff = 1;
        fac_data = {8'($urandom), 5'd0};
      end else if (sel == 1) begin
        f_eff = 16;
        fac_data = {8'($urandom), 5'($urandom_range(16, 31))};
        wb = 1;
        hb = 1;
      end else if (sel == 2) begin
        f_eff = $urandom_range(5, 15);
        fac_data = {8'($urandom), 5'(f_eff)};
        wb = $urandom_range(1, 2);
        hb = 1;
      end else begin
        f_eff = $urandom_range(1, 4);
        fac_data = {8'($urandom), 5'(f_eff)};
      end
      crop_max = (f_eff > 4) ? 3 : f_eff - 1;
      w = f_eff * wb + $urandom_range(0, crop_max);
      h = f_eff * hb + $urandom_range(0, crop_max);
      case (phase)
        0: begin w = 0;    h = 4096; end
        1: begin w = 1;    h = 8191; end
        2: begin w = 4096; h = 0;    end
        3: begin w = 8191; h = 1;    end
        default: ;
      endcase
      frame = clamp_dim(w, MAX_WIDTH_DEF) * clamp_dim(h, MAX_HEIGHT);
      if (frame <= 600) n = frame * $urandom_range(1, 2) + $urandom_range(0, frame - 1);
      else n = $urandom_range(20, 150);
      if (n > 800) n = 800;

      reg_order = '{CFG_FACTOR, CFG_WIDTH, CFG_HEIGHT};
      if ($urandom_range(0, 3) == 0) reg_order.push_back(CFG_SPARE);
      reg_order.shuffle();
      foreach (reg_order[k]) begin
        case (reg_order[k])
          CFG_FACTOR: val = fac_data;
          CFG_WIDTH:  val = DIM_W'(w);
          CFG_HEIGHT: val = DIM_W'(h);
          default:    val = DIM_W'($urandom);
        endcase
        write_reg(reg_order[k], val);
      end

      // Half the frames are cut short by a restart part way through.
      split = ($urandom_range(0, 1) == 1 && n > 1) ? $urandom_range(1, n - 1) : n;
      repeat (split) pix_pending.push_back(rand_pixel());
      if (split < n) begin
        wait_drained();
        write_reg(CFG_SPARE, DIM_W'($urandom));
        repeat (n - split) pix_pending.push_back(rand_pixel());
      end
      items_sent += n;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("box_filter_downsampler_tb: clean");
    end else begin
      $display("box_filter_downsampler_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
